FILE: hdl/skfi_pkg.sv
// ----------------------------------------------------------------------------
// skfi_pkg
// shared types and constants of the servo keyframe interpolator
// ----------------------------------------------------------------------------
package skfi_pkg;

   // item mode codes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // quotient width of the interpolation divide (duty range)
   localparam int Q_BITS = 8;

   // one stored move
   typedef struct packed {
      logic [31:0] begin_time;
      logic [31:0] finish_time;
      logic [7:0]  begin_duty;
      logic [7:0]  finish_duty;
      logic [3:0]  servo;
   } move_entry_type;

   localparam int MOVE_W = $bits(move_entry_type);

   // sequencer to interpolation unit
   typedef struct packed {
      logic           start;
      move_entry_type entry;
      logic [31:0]    tick_time;
   } interp_ctrl_type;

   // interpolation unit back to sequencer
   typedef struct packed {
      logic       done;
      logic [7:0] duty;
   } interp_stat_type;

endpackage

FILE: hdl/skfi_ram.sv
// ----------------------------------------------------------------------------
// skfi_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module skfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/skfi_interp.sv
// ----------------------------------------------------------------------------
// skfi_interp
// linear duty interpolation: one 8x32 multiply, then an 8-step restoring
// divide through one shared subtract/compare unit, floored toward -inf
// ----------------------------------------------------------------------------
module skfi_interp (
   input  logic                      clock,
   input  logic                      reset,
   input  skfi_pkg::interp_ctrl_type ctrl,
   output skfi_pkg::interp_stat_type stat
);

   localparam logic [2:0] I_IDLE = 3'd0;
   localparam logic [2:0] I_MUL  = 3'd1;
   localparam logic [2:0] I_DIV  = 3'd2;
   localparam logic [2:0] I_FIN  = 3'd3;

   localparam int SW = $clog2(skfi_pkg::Q_BITS);

   logic [2:0]                  state_ff, state_in;
   logic [SW-1:0]               step_ff, step_in;
   logic                        done_ff, done_in;
   logic [31:0]                 span_ff, span_in;
   logic [31:0]                 elap_ff, elap_in;
   logic                        neg_ff, neg_in;
   logic [7:0]                  mag_ff, mag_in;
   logic [7:0]                  sduty_ff, sduty_in;
   logic [7:0]                  eduty_ff, eduty_in;
   logic [31:0]                 rem_ff, rem_in;
   logic [skfi_pkg::Q_BITS-1:0] lo_ff, lo_in;
   logic [skfi_pkg::Q_BITS-1:0] quo_ff, quo_in;
   logic [7:0]                  duty_ff, duty_in;

   logic [8:0]  diff;
   logic [39:0] prod;
   logic [33:0] trial;
   logic [8:0]  quo_up;
   logic [9:0]  sum_pos;
   logic [9:0]  sum_neg;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      span_ff  <= span_in;
      elap_ff  <= elap_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      sduty_ff <= sduty_in;
      eduty_ff <= eduty_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
      quo_ff   <= quo_in;
      duty_ff  <= duty_in;
   end

   // signed duty difference and its magnitude
   assign diff = {1'b0, ctrl.entry.finish_duty} - {1'b0, ctrl.entry.begin_duty};

   // unsigned product of magnitude and elapsed time
   assign prod = {32'd0, mag_ff} * {8'd0, elap_ff};

   // shared subtract and compare for one quotient bit
   assign trial = {1'b0, rem_ff, lo_ff[skfi_pkg::Q_BITS-1]} - {2'b00, span_ff};

   // final floor correction for a negative slope
   assign quo_up  = {1'b0, quo_ff} + {8'd0, (rem_ff != 32'd0)};
   assign sum_pos = {2'b00, sduty_ff} + {2'b00, quo_ff};
   assign sum_neg = {2'b00, sduty_ff} - {1'b0, quo_up};

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      span_in  = span_ff;
      elap_in  = elap_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      sduty_in = sduty_ff;
      eduty_in = eduty_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      quo_in   = quo_ff;
      duty_in  = duty_ff;
      case (state_ff)
         I_IDLE: begin
            if (ctrl.start) begin
               span_in  = ctrl.entry.finish_time - ctrl.entry.begin_time;
               elap_in  = ctrl.tick_time - ctrl.entry.begin_time;
               neg_in   = diff[8];
               mag_in   = diff[8] ? 8'(-diff) : diff[7:0];
               sduty_in = ctrl.entry.begin_duty;
               eduty_in = ctrl.entry.finish_duty;
               state_in = I_MUL;
            end
         end
         I_MUL: begin
            // quotient stays below 256, so the top 32 bits are below the span
            rem_in   = prod[39:skfi_pkg::Q_BITS];
            lo_in    = prod[skfi_pkg::Q_BITS-1:0];
            quo_in   = '0;
            step_in  = '0;
            state_in = I_DIV;
         end
         I_DIV: begin
            if (!trial[33]) begin
               rem_in = trial[31:0];
            end else begin
               rem_in = {rem_ff[30:0], lo_ff[skfi_pkg::Q_BITS-1]};
            end
            quo_in  = {quo_ff[skfi_pkg::Q_BITS-2:0], ~trial[33]};
            lo_in   = {lo_ff[skfi_pkg::Q_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(skfi_pkg::Q_BITS - 1)) begin
               state_in = I_FIN;
            end
         end
         I_FIN: begin
            // zero-length move takes its end duty
            if (span_ff == 32'd0) begin
               duty_in = eduty_ff;
            end else if (neg_ff) begin
               duty_in = sum_neg[7:0];
            end else begin
               duty_in = sum_pos[7:0];
            end
            done_in  = 1'b1;
            state_in = I_IDLE;
         end
         default: begin
            state_in = I_IDLE;
         end
      endcase
   end

   assign stat.done = done_ff;
   assign stat.duty = duty_ff;

endmodule

FILE: hdl/servo_keyframe_interpolator_unit.sv
// ----------------------------------------------------------------------------
// servo_keyframe_interpolator_unit
// servo move table with per-servo duty interpolation on time ticks
// ----------------------------------------------------------------------------
// A load transaction (mode 0) writes one move into the table and returns
// nothing. A tick transaction (mode 1) walks entries 0 to active_moves-1
// (saturated at TABLE_DEPTH) and then returns SERVO_COUNT transactions, one
// per servo, the last one flagged. The walk reads one table entry per visit
// through the table memory's single read port: an entry whose window misses
// the time passes through the read, check and next states, and a matching
// entry also waits in the wait state for the interpolation unit's multiply
// and its 8-step iterative divide. The block takes no new transaction while
// a tick is in progress, also while its result transactions are held by an
// output stall. The table reads as all zero after reset through per-entry
// valid bits, so no clearing pass is needed.
module servo_keyframe_interpolator_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int SERVO_COUNT = 12,
   parameter int INIT_DUTY   = 75
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [4:0]  req_move_index,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_end_time,
   input  logic [7:0]  req_start_duty,
   input  logic [7:0]  req_end_duty,
   input  logic [3:0]  req_move_servo,
   input  logic [31:0] req_tick_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_servo_index,
   output logic [7:0]  rsp_duty_value,
   output logic        rsp_last_servo,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = CW + 6;
   localparam int SW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_NEXT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [5:0]             active_ff, active_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          lim_ff, lim_in;
   logic [SW-1:0]          oc_ff, oc_in;
   logic [31:0]            tick_ff, tick_in;
   logic [TABLE_DEPTH-1:0] vld_ff, vld_in;
   logic                   vld_rd_ff, vld_rd_in;
   logic [7:0]             duty_ff [SERVO_COUNT];
   logic [7:0]             duty_in [SERVO_COUNT];

   logic                     req_acc;
   logic                     rsp_acc;
   logic                     load_ok;
   logic [AW+4:0]            load_wide;
   logic [AW-1:0]            load_addr;
   logic [LW-1:0]            am_wide;
   logic [LW-1:0]            td_wide;
   logic [LW-1:0]            lim_wide;
   logic [CW-1:0]            idx_next;
   logic                     ram_rd_en;
   logic [skfi_pkg::MOVE_W-1:0] ram_rd_data;
   skfi_pkg::move_entry_type load_entry;
   skfi_pkg::move_entry_type cur_entry;
   logic                     in_window;
   logic                     servo_ok;
   skfi_pkg::interp_ctrl_type interp_ctrl;
   skfi_pkg::interp_stat_type interp_stat;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // load slot decode, ignored beyond the table
   assign load_wide = {{AW{1'b0}}, req_move_index};
   assign load_addr = load_wide[AW-1:0];
   assign load_ok   = req_acc && (req_mode == skfi_pkg::MODE_LOAD)
                      && (load_wide < (AW+5)'(TABLE_DEPTH));

   assign load_entry.begin_time  = req_start_time;
   assign load_entry.finish_time = req_end_time;
   assign load_entry.begin_duty  = req_start_duty;
   assign load_entry.finish_duty = req_end_duty;
   assign load_entry.servo       = req_move_servo;

   // saturated walk length
   assign am_wide  = {{CW{1'b0}}, active_ff};
   assign td_wide  = LW'(TABLE_DEPTH);
   assign lim_wide = (am_wide > td_wide) ? td_wide : am_wide;
   assign idx_next = idx_ff + 1'b1;

   // move table
   assign ram_rd_en = (state_ff == S_READ);

   skfi_ram #(
      .WIDTH (skfi_pkg::MOVE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (load_addr),
      .wr_data (load_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // never-written entry reads as all zero
   assign cur_entry = vld_rd_ff ? skfi_pkg::move_entry_type'(ram_rd_data) : '0;
   assign in_window = (cur_entry.begin_time <= tick_ff) && (tick_ff <= cur_entry.finish_time);
   assign servo_ok  = {1'b0, cur_entry.servo} < 5'(SERVO_COUNT);

   // interpolation unit
   assign interp_ctrl.start     = (state_ff == S_CHECK) && in_window;
   assign interp_ctrl.entry     = cur_entry;
   assign interp_ctrl.tick_time = tick_ff;

   skfi_interp u_interp (
      .clock (clock),
      .reset (reset),
      .ctrl  (interp_ctrl),
      .stat  (interp_stat)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         idx_ff    <= '0;
         oc_ff     <= '0;
         vld_ff    <= '0;
         for (int i = 0; i < SERVO_COUNT; i++) begin
            duty_ff[i] <= 8'(INIT_DUTY);
         end
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
         oc_ff     <= oc_in;
         vld_ff    <= vld_in;
         for (int i = 0; i < SERVO_COUNT; i++) begin
            duty_ff[i] <= duty_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lim_ff    <= lim_in;
      tick_ff   <= tick_in;
      vld_rd_ff <= vld_rd_in;
   end

   // tick sequencer
   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      oc_in     = oc_ff;
      tick_in   = tick_ff;
      vld_in    = vld_ff;
      vld_rd_in = vld_rd_ff;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         duty_in[i] = duty_ff[i];
      end
      if (csr_write_enable) begin
         active_in = csr_write_data;
      end
      if (load_ok) begin
         vld_in[load_addr] = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_mode == skfi_pkg::MODE_TICK)) begin
               tick_in = req_tick_time;
               lim_in  = lim_wide[CW-1:0];
               idx_in  = '0;
               oc_in   = '0;
               if (lim_wide == '0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            vld_rd_in = vld_ff[idx_ff[AW-1:0]];
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (in_window) begin
               state_in = S_WAIT;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_WAIT: begin
            if (interp_stat.done) begin
               if (servo_ok) begin
                  duty_in[cur_entry.servo[SW-1:0]] = interp_stat.duty;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            idx_in = idx_next;
            if (idx_next == lim_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (rsp_acc) begin
               oc_in = oc_ff + 1'b1;
               if (rsp_last_servo) begin
                  oc_in    = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // handshakes and result transaction
   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_servo_index = 4'(oc_ff);
   assign rsp_duty_value  = duty_ff[oc_ff];
   assign rsp_last_servo  = (oc_ff == SW'(SERVO_COUNT - 1));

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("input accepted while results pending");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_servo |=> req_ready)
      else $error("block not ready after last result");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      interp_stat.done |-> state_ff == S_WAIT)
      else $error("interpolation finished outside wait state");

   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_servo_index < 4'(SERVO_COUNT))
      else $error("reported servo index out of range");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> idx_ff < lim_ff)
      else $error("table walk beyond active moves");
`endif

endmodule

FILE: tb/servo_keyframe_interpolator_unit_test.sv
// ----------------------------------------------------------------------------
// servo_keyframe_interpolator_unit_test
// self-checking bench for the servo keyframe interpolator unit
// ----------------------------------------------------------------------------
// A directed table covers reset values, window extremes, zero-length,
// reversed and out-of-range moves and the active_moves saturation. A random
// part follows, made mostly of loads and ticks around a common time base.
// Every tick transaction is run through a local model of the move table and
// servo duties, and the twelve duty transactions are checked field by field
// in order. Both handshakes stall at random, save in the last random phase.
module servo_keyframe_interpolator_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = 32;
   localparam int SERVO_COUNT   = 12;
   localparam int INIT_DUTY     = 75;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 97;

   typedef logic [SERVO_COUNT-1:0][7:0] duty_set_type;

   // one input transaction
   typedef struct packed {
      logic                     mode;
      logic [4:0]               slot;
      skfi_pkg::move_entry_type mv;
      logic [31:0]              tick;
   } request_type;

   // one duty transaction
   typedef struct packed {
      logic [3:0] servo;
      logic [7:0] duty;
      logic       last;
   } servo_result_type;

   // directed stimulus row
   typedef struct {
      logic      is_csr;
      logic [5:0] csr_value;
      request_type  req;
      logic      lit_on;
      duty_set_type lit;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [4:0]  req_move_index = '0;
   logic [31:0] req_start_time = '0;
   logic [31:0] req_end_time = '0;
   logic [7:0]  req_start_duty = '0;
   logic [7:0]  req_end_duty = '0;
   logic [3:0]  req_move_servo = '0;
   logic [31:0] req_tick_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_servo_index;
   logic [7:0]  rsp_duty_value;
   logic        rsp_last_servo;
   logic        csr_write_enable = 1'b0;
   logic [5:0]  csr_write_data = '0;

   // model state
   skfi_pkg::move_entry_type model_moves [TABLE_DEPTH];
   logic [7:0]     model_duty [SERVO_COUNT];
   logic [5:0]     model_active;

   servo_result_type duty_queue [$];
   stim_row_type     directed [$];
   int            error_count = 0;
   int            send_idle_pct = 13;
   int            recv_idle_pct = 48;

   servo_keyframe_interpolator_unit #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SERVO_COUNT (SERVO_COUNT),
      .INIT_DUTY   (INIT_DUTY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_move_index   (req_move_index),
      .req_start_time   (req_start_time),
      .req_end_time     (req_end_time),
      .req_start_duty   (req_start_duty),
      .req_end_duty     (req_end_duty),
      .req_move_servo   (req_move_servo),
      .req_tick_time    (req_tick_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_servo_index  (rsp_servo_index),
      .rsp_duty_value   (rsp_duty_value),
      .rsp_last_servo   (rsp_last_servo),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("** servo_keyframe_interpolator_unit: FAILED **");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // linear interpolation, exact and floored
   function automatic logic [7:0] interp_duty(input skfi_pkg::move_entry_type m,
                                              input logic [31:0] t);
      longint span, elapsed, d_start, d_end, num, q;
      span    = {32'd0, m.finish_time} - {32'd0, m.begin_time};
      elapsed = {32'd0, t} - {32'd0, m.begin_time};
      if (span == 0) return m.finish_duty;
      d_start = m.begin_duty;
      d_end   = m.finish_duty;
      num = (d_end - d_start) * elapsed;
      q = num / span;
      if (num < 0 && q * span != num) q = q - 1;
      q = q + d_start;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   task automatic reset_model();
      for (int i = 0; i < TABLE_DEPTH; i++) model_moves[i] = '0;
      for (int i = 0; i < SERVO_COUNT; i++) model_duty[i] = INIT_DUTY[7:0];
      model_active = '0;
   endtask

   // apply an accepted transaction to the model and queue its duties
   task automatic accept_request(input request_type r, input logic lit_on,
                                 input duty_set_type lit);
      int walk;
      skfi_pkg::move_entry_type m;
      if (r.mode == skfi_pkg::MODE_LOAD) begin
         if (r.slot < TABLE_DEPTH) model_moves[r.slot] = r.mv;
      end else begin
         walk = (model_active > TABLE_DEPTH) ? TABLE_DEPTH : model_active;
         for (int i = 0; i < walk; i++) begin
            m = model_moves[i];
            if (m.begin_time <= r.tick && r.tick <= m.finish_time && m.servo < SERVO_COUNT)
               model_duty[m.servo] = interp_duty(m, r.tick);
         end
         for (int i = 0; i < SERVO_COUNT; i++)
            duty_queue.push_back('{servo: i[3:0],
                                   duty: lit_on ? lit[i] : model_duty[i],
                                   last: (i == SERVO_COUNT - 1)});
      end
   endtask

   // drive one transaction and wait for the handshake
   task automatic send_request(input request_type r, input logic lit_on,
                               input duty_set_type lit);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode       = r.mode;
      req_move_index = r.slot;
      req_start_time = r.mv.begin_time;
      req_end_time   = r.mv.finish_time;
      req_start_duty = r.mv.begin_duty;
      req_end_duty   = r.mv.finish_duty;
      req_move_servo = r.mv.servo;
      req_tick_time  = r.tick;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      accept_request(r, lit_on, lit);
   endtask

   // wait for the block to go idle
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_moves(input logic [5:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      model_active     = value;
   endtask

   // directed row builders
   function automatic stim_row_type load_row(input logic [4:0] slot, input logic [31:0] t0,
                                             input logic [31:0] t1, input logic [7:0] d0,
                                             input logic [7:0] d1, input logic [3:0] servo);
      stim_row_type row;
      row = '{is_csr: 1'b0, csr_value: '0, req: '0, lit_on: 1'b0, lit: '0};
      row.req.mode = skfi_pkg::MODE_LOAD;
      row.req.slot = slot;
      row.req.mv   = '{begin_time: t0, finish_time: t1, begin_duty: d0, finish_duty: d1,
                       servo: servo};
      return row;
   endfunction

   function automatic stim_row_type tick_row(input logic [31:0] t, input logic lit_on,
                                             input duty_set_type lit);
      stim_row_type row;
      row = '{is_csr: 1'b0, csr_value: '0, req: '0, lit_on: lit_on, lit: lit};
      row.req.mode = skfi_pkg::MODE_TICK;
      row.req.tick = t;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [5:0] value);
      return '{is_csr: 1'b1, csr_value: value, req: '0, lit_on: 1'b0, lit: '0};
   endfunction

   // random transaction, mostly loads and ticks around a shared time base
   function automatic request_type random_request(input logic [31:0] base);
      request_type r;
      int pick, shape;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // noise: every field random
         r.mode = 1'($urandom_range(1));
         r.slot = 5'($urandom);
         r.mv   = '{begin_time: $urandom, finish_time: $urandom,
                    begin_duty: 8'($urandom), finish_duty: 8'($urandom),
                    servo: 4'($urandom)};
         r.tick = $urandom;
      end else if (pick < 60) begin
         r.mode = skfi_pkg::MODE_LOAD;
         r.slot = 5'($urandom_range(TABLE_DEPTH - 1));
         r.mv.begin_time = base + $urandom_range(2000);
         shape = $urandom_range(9);
         if (shape == 0) r.mv.finish_time = r.mv.begin_time;
         else if (shape == 1) r.mv.finish_time = r.mv.begin_time - $urandom_range(1, 100);
         else if (shape == 2) r.mv.finish_time = r.mv.begin_time + $urandom;
         else r.mv.finish_time = r.mv.begin_time + $urandom_range(1, 500);
         r.mv.begin_duty  = 8'($urandom);
         r.mv.finish_duty = 8'($urandom);
         r.mv.servo = 4'(($urandom_range(9) == 0) ? $urandom_range(SERVO_COUNT, 15)
                                                  : $urandom_range(SERVO_COUNT - 1));
         r.tick = $urandom;
      end else begin
         r.mode = skfi_pkg::MODE_TICK;
         r.slot = 5'($urandom);
         r.mv   = '{begin_time: $urandom, finish_time: $urandom,
                    begin_duty: 8'($urandom), finish_duty: 8'($urandom),
                    servo: 4'($urandom)};
         r.tick = base + $urandom_range(2600);
      end
      return r;
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin : watch_results
      servo_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_queue.size() == 0) begin
            flag_mismatch($sformatf("unexpected transaction servo %0d duty %0d last %0b",
                                    rsp_servo_index, rsp_duty_value, rsp_last_servo));
         end else begin
            want = duty_queue.pop_front();
            if (rsp_servo_index !== want.servo)
               flag_mismatch($sformatf("servo_index %0d, want %0d",
                                       rsp_servo_index, want.servo));
            if (rsp_duty_value !== want.duty)
               flag_mismatch($sformatf("servo %0d duty_value %0d, want %0d",
                                       want.servo, rsp_duty_value, want.duty));
            if (rsp_last_servo !== want.last)
               flag_mismatch($sformatf("servo %0d last_servo %0b, want %0b",
                                       want.servo, rsp_last_servo, want.last));
         end
      end
   end

   // stimulus
   initial begin : stimulus
      logic [31:0] base;
      reset_model();

      // directed rows
      directed.push_back(tick_row(32'd0, 1'b1, {SERVO_COUNT{8'd75}}));
      directed.push_back(csr_row(6'd1));
      // zeroed entry after reset is a zero-length move on servo 0
      directed.push_back(tick_row(32'd0, 1'b1, {{11{8'd75}}, 8'd0}));
      directed.push_back(tick_row(32'd1, 1'b1, {{11{8'd75}}, 8'd0}));
      directed.push_back(load_row(5'd0, 32'd0, 32'hFFFF_FFFF, 8'd0, 8'd255, 4'd0));
      directed.push_back(tick_row(32'hFFFF_FFFF, 1'b1, {{11{8'd75}}, 8'd255}));
      directed.push_back(tick_row(32'd0, 1'b1, {{11{8'd75}}, 8'd0}));
      directed.push_back(tick_row(32'h8000_0000, 1'b0, '0));
      // zero-length move on the top servo
      directed.push_back(load_row(5'd1, 32'd100, 32'd100, 8'd10, 8'd200, 4'd11));
      directed.push_back(csr_row(6'd2));
      directed.push_back(tick_row(32'd100, 1'b1, {8'd200, {10{8'd75}}, 8'd0}));
      // reversed window and a falling ramp
      directed.push_back(load_row(5'd2, 32'd500, 32'd400, 8'd0, 8'd255, 4'd5));
      directed.push_back(load_row(5'd3, 32'd1000, 32'd1003, 8'd255, 8'd0, 4'd3));
      directed.push_back(csr_row(6'd4));
      directed.push_back(tick_row(32'd1001, 1'b0, '0));
      directed.push_back(tick_row(32'd450, 1'b0, '0));
      // servo out of range, last slot, saturated walk length
      directed.push_back(load_row(5'd4, 32'd0, 32'hFFFF_FFFF, 8'd255, 8'd255, 4'd15));
      directed.push_back(load_row(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 8'd171, 4'd6));
      directed.push_back(csr_row(6'd63));
      directed.push_back(tick_row(32'hFFFF_FFFF, 1'b0, '0));
      // later entry overrides servo 0
      directed.push_back(load_row(5'd5, 32'd0, 32'd2000, 8'd40, 8'd41, 4'd0));
      directed.push_back(csr_row(6'd32));
      directed.push_back(tick_row(32'd1999, 1'b0, '0));
      directed.push_back(csr_row(6'd0));
      directed.push_back(tick_row(32'd1002, 1'b0, '0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            drain_block();
            write_active_moves(directed[i].csr_value);
         end else begin
            send_request(directed[i].req, directed[i].lit_on, directed[i].lit);
         end
      end

      // random phases with different idling
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 13 : 0;
         drain_block();
         write_active_moves(6'((phase == 0) ? $urandom_range(20, 32) :
                               (phase == 1) ? $urandom_range(33, 63) :
                                              $urandom_range(1, 31)));
         base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(10000);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
               drain_block();
               write_active_moves(6'($urandom_range(63)));
               base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(10000);
            end
            send_request(random_request(base), 1'b0, '0);
         end
      end

      drain_block();
      if (error_count == 0) begin
         $display("** servo_keyframe_interpolator_unit: PASSED **");
      end else begin
         $display("** servo_keyframe_interpolator_unit: FAILED **");
      end
      $finish;
   end

endmodule
